// ===== rtl/bpfr_pkg.sv =====
// Package for the buffer pool frame replacement core.
// Holds sizes, operation codes and the sequencer state type; no dependencies.
package bpfr_pkg;
    localparam int FRAMES     = 16;
    localparam int PAGE_BITS  = 24;
    localparam int FRAME_BITS = $clog2(FRAMES);
    localparam int PIN_BITS   = 16;
    localparam int CNT_BITS   = 32;

    localparam logic [2:0] KIND_PIN   = 3'd0;
    localparam logic [2:0] KIND_UNPIN = 3'd1;
    localparam logic [2:0] KIND_DIRTY = 3'd2;
    localparam logic [2:0] KIND_FORCE = 3'd3;
    localparam logic [2:0] KIND_FLUSH = 3'd4;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_FIND  = 7'b0000010,
        ST_EMPTY = 7'b0000100,
        ST_VICT  = 7'b0001000,
        ST_MOVE  = 7'b0010000,
        ST_FLUSH = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;
endpackage

// ===== rtl/buffer_pool_frame_replacement_core.sv =====
// Buffer pool frame manager with FIFO or LRU replacement.
// A lookup scans the frames, one per cycle; a pin miss then adds an empty-frame
// scan, a victim scan when no frame is empty, and an order update.
// One item is taken at a time, only from idle; a flush emits one result per dirty
// unpinned frame, or a single empty one. Reset (aresetn, synchronous, active low)
// empties every frame, restores frame i in slot i, clears counters and strategy.
module buffer_pool_frame_replacement_core import bpfr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // kind[2:0], page_num[26:3], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // status, hit, frame, read_issue, write_issue,
                                   // write_page, read_count, write_count
    output logic        m_tlast
);
    localparam int FB = FRAME_BITS;

    state_t state_reg;
    logic [PAGE_BITS-1:0] page_reg [FRAMES];
    logic [FRAMES-1:0]    valid_reg, dirty_reg;
    logic [PIN_BITS-1:0]  pins_reg [FRAMES];
    logic [FB-1:0]        order_reg [FRAMES];
    logic [CNT_BITS-1:0]  rcnt_reg, wcnt_reg;
    logic                 strat_reg;
    logic [2:0]           kind_reg;
    logic [PAGE_BITS-1:0] req_reg;
    logic [FB-1:0]        idx_reg;
    logic [FB-1:0]        tgt_reg;
    logic                 hit_reg, found_reg;
    logic                 o_status, o_hit, o_rd, o_wr, o_last;
    logic [FB-1:0]        o_frame;
    logic [PAGE_BITS-1:0] o_wpage;

    logic [FB-1:0]     ix, of;
    logic              match, cand;
    logic [FRAMES-1:0] qual, of_bit;

    assign ix     = idx_reg;
    assign of     = order_reg[ix];
    assign match  = valid_reg[ix] && (page_reg[ix] == req_reg);
    assign cand   = (state_reg == ST_EMPTY) ? !valid_reg[of] : (pins_reg[of] == '0);
    assign of_bit = FRAMES'(1) << of;

    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            qual[i] = valid_reg[i] && dirty_reg[i] && (pins_reg[i] == '0);
        end
    end

    assign cfg_ready = (state_reg == ST_IDLE) && !s_tvalid;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tlast   = o_last;
    assign m_tdata = {wcnt_reg, rcnt_reg, o_wpage, o_wr, o_rd, o_frame, o_hit, o_status};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            dirty_reg <= '0;
            rcnt_reg  <= '0;
            wcnt_reg  <= '0;
            strat_reg <= 1'b0;
            for (int i = 0; i < FRAMES; i++) begin
                pins_reg[i]  <= '0;
                order_reg[i] <= FB'(i);
            end
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (cfg_valid && cfg_ready) strat_reg <= cfg_data;
                    if (s_tvalid) begin
                        kind_reg  <= s_tdata[2:0];
                        req_reg   <= s_tdata[3 +: PAGE_BITS];
                        idx_reg   <= '0;
                        hit_reg   <= 1'b0;
                        found_reg <= 1'b0;
                        {o_status, o_hit, o_rd, o_wr} <= '0;
                        o_last  <= (s_tdata[2:0] > KIND_FLUSH);
                        o_frame <= '0;
                        o_wpage <= '0;
                        if (s_tdata[2:0] == KIND_FLUSH) state_reg <= ST_FLUSH;
                        else if (s_tdata[2:0] > KIND_FLUSH) state_reg <= ST_OUT;
                        else state_reg <= ST_FIND;
                    end
                end
                ST_FIND: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (ix != FB'(FRAMES-1)) begin
                        if (!hit_reg && match) begin
                            hit_reg <= 1'b1;
                            tgt_reg <= ix;
                        end
                    end else begin
                        o_last <= 1'b1;
                        if (!hit_reg && !match) begin
                            state_reg <= (kind_reg == KIND_PIN) ? ST_EMPTY : ST_OUT;
                        end else begin
                            logic [FB-1:0] h;
                            h = hit_reg ? tgt_reg : ix;
                            o_hit <= 1'b1;
                            o_frame <= h;
                            tgt_reg <= h;
                            state_reg <= (kind_reg == KIND_PIN && strat_reg) ? ST_MOVE
                                                                             : ST_OUT;
                            case (kind_reg)
                                KIND_PIN:
                                    if (pins_reg[h] != '1) pins_reg[h] <= pins_reg[h] + 1'b1;
                                KIND_UNPIN:
                                    if (pins_reg[h] != '0) pins_reg[h] <= pins_reg[h] - 1'b1;
                                KIND_DIRTY: dirty_reg[h] <= 1'b1;
                                default:
                                    if (pins_reg[h] == '0 && dirty_reg[h]) begin
                                        dirty_reg[h] <= 1'b0;
                                        o_wr <= 1'b1;
                                        o_wpage <= page_reg[h];
                                        if (wcnt_reg != '1) wcnt_reg <= wcnt_reg + 1'b1;
                                    end
                            endcase
                        end
                    end
                end
                ST_EMPTY, ST_VICT: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (ix != FB'(FRAMES-1)) begin
                        if (!found_reg && cand) begin
                            found_reg <= 1'b1;
                            tgt_reg <= of;
                        end
                    end else begin
                        logic fnd;
                        logic [FB-1:0] f;
                        fnd = found_reg || cand;
                        f = found_reg ? tgt_reg : of;
                        if (fnd) begin
                            found_reg <= 1'b0;
                            tgt_reg <= f;
                            o_frame <= f;
                            o_rd <= 1'b1;
                            if (valid_reg[f] && dirty_reg[f]) begin
                                o_wr <= 1'b1;
                                o_wpage <= page_reg[f];
                                if (wcnt_reg != '1) wcnt_reg <= wcnt_reg + 1'b1;
                            end
                            if (rcnt_reg != '1) rcnt_reg <= rcnt_reg + 1'b1;
                            page_reg[f] <= req_reg;
                            valid_reg[f] <= 1'b1;
                            dirty_reg[f] <= 1'b0;
                            pins_reg[f] <= PIN_BITS'(1);
                            state_reg <= ST_MOVE;
                        end else if (state_reg == ST_EMPTY) state_reg <= ST_VICT;
                        else begin
                            o_status <= 1'b1;
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_MOVE: begin
                    // From the target's slot onward, each slot takes its successor; the last takes the target.
                    if (found_reg || of == tgt_reg) begin
                        found_reg <= 1'b1;
                        order_reg[ix] <= (ix == FB'(FRAMES-1)) ? tgt_reg
                                        : order_reg[idx_reg + 1'b1];
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (ix == FB'(FRAMES-1)) state_reg <= ST_OUT;
                end
                ST_FLUSH: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (qual[of]) begin
                        dirty_reg[of] <= 1'b0;
                        if (wcnt_reg != '1) wcnt_reg <= wcnt_reg + 1'b1;
                        o_frame <= of;
                        o_wr <= 1'b1;
                        o_wpage <= page_reg[of];
                        o_last <= ~|(qual & ~of_bit);
                        state_reg <= ST_OUT;
                    end else if (ix == FB'(FRAMES-1)) begin
                        o_frame <= '0;
                        o_wr <= 1'b0;
                        o_wpage <= '0;
                        o_last <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        if (kind_reg == KIND_FLUSH && !o_last) state_reg <= ST_FLUSH;
                        else state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // A flush write-back carries last when no other frame is left to write.
endmodule
